// ----- sv/max_mcs_grant_scheduler_core_assert.svh -----
// Assertion macros for the grant scheduler core
`ifndef MAX_MCS_GRANT_SCHEDULER_CORE_ASSERT_SVH
`define MAX_MCS_GRANT_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication under clk, disabled while arst_n is low
`define MMGS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grant scheduler: same-cycle check failed");

// next-cycle implication under clk, disabled while arst_n is low
`define MMGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grant scheduler: next-cycle check failed");

`endif

// ----- sv/mmgs_pkg.sv -----
// Types and constants of the maximum-rate grant scheduler
package mmgs_pkg;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	localparam logic [4:0] RATE_MAX     = 5'd27;
	localparam logic [7:0] BLOCKS_RESET = 8'd100;
	localparam logic [3:0] ACTIVE_MAX   = 4'd15;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] user_id;
		logic [4:0]  rate_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        granted;
		logic [15:0] grant_user;
		logic [4:0]  grant_rate;
		logic [7:0]  grant_blocks;
		logic [3:0]  active_users;
	} out_word_t;

	typedef struct packed {
		logic [15:0] user;
		logic [4:0]  rate;
	} slot_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} state_t;

endpackage

// ----- sv/mmgs_slot_ram.sv -----
// Slot table memory: one write port, one read port, registered read data
module mmgs_slot_ram #(
	parameter int DEPTH = 12,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  mmgs_pkg::slot_t      wdata,
	input  logic [AW-1:0]        raddr,
	output mmgs_pkg::slot_t      rdata
);

	mmgs_pkg::slot_t mem_q [DEPTH];
	mmgs_pkg::slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/max_mcs_grant_scheduler_core.sv -----
// Top level of the maximum-rate grant scheduler core
//
// channel   handshake        word          direction
// command   start / busy     cmd           in
// result    done (strobe)    result        out
// config    cfg_we           cfg_wdata     in
//
// An item is taken when start is high and busy low; its result strobes on done
// after the scan, which reads one slot a cycle from the slot memory, a drain state
// for the read latency and an update state; done is registered from the update.
// busy is high in scan, drain and update; a new item may be taken while done shows.
// Reset clears all slots' valid bits and the user count; blocks_per_grant goes to 100.
// The receiver cannot stall: done strobes each result for one cycle only.
`include "max_mcs_grant_scheduler_core_assert.svh"

module max_mcs_grant_scheduler_core #(
	parameter int SLOTS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mmgs_pkg::in_word_t    cmd,
	output logic                  done,
	output mmgs_pkg::out_word_t   result,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	mmgs_pkg::state_t    state_q, state_d;
	logic [SLOTS-1:0]    valid_q;
	logic [CW-1:0]       count_q, count_d;
	logic [7:0]          blocks_q;
	logic                done_q;
	mmgs_pkg::out_word_t result_q, result_d;

	logic [1:0]          kind_q;
	logic [15:0]         user_q;
	logic [4:0]          rate_q;
	logic [IW-1:0]       idx_q;
	logic                found_q;
	logic [IW-1:0]       fidx_q;
	logic [15:0]         best_user_q;
	logic [4:0]          best_rate_q;

	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;

	logic                accept;
	logic                ram_we;
	mmgs_pkg::slot_t     ram_wdata;
	mmgs_pkg::slot_t     ram_rdata;
	logic                hit;
	logic                add_ok, rem_ok;

	assign accept = start && !busy;

	mmgs_slot_ram #(
		.DEPTH(SLOTS),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fidx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign ram_wdata.user = user_q;
	assign ram_wdata.rate = rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmgs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign add_ok = (kind_q == mmgs_pkg::KIND_ADD) && found_q;
	assign rem_ok = (kind_q == mmgs_pkg::KIND_REMOVE) && found_q;

	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		ram_we   = 1'b0;
		count_d  = count_q;
		result_d = '0;
		if (add_ok) begin
			count_d = count_q + CW'(1);
		end else if (rem_ok) begin
			count_d = count_q - CW'(1);
		end
		result_d.active_users = (32'(count_d) > 32'(mmgs_pkg::ACTIVE_MAX)) ?
			mmgs_pkg::ACTIVE_MAX : 4'(count_d);
		case (kind_q)
			mmgs_pkg::KIND_ADD: begin
				result_d.status = found_q ? mmgs_pkg::STAT_OK : mmgs_pkg::STAT_FULL;
			end
			mmgs_pkg::KIND_REMOVE: begin
				result_d.status = found_q ? mmgs_pkg::STAT_OK : mmgs_pkg::STAT_NOT_FOUND;
			end
			mmgs_pkg::KIND_TICK: begin
				result_d.status = found_q ? mmgs_pkg::STAT_OK : mmgs_pkg::STAT_EMPTY;
				if (found_q) begin
					result_d.granted      = 1'b1;
					result_d.grant_user   = best_user_q;
					result_d.grant_rate   = best_rate_q;
					result_d.grant_blocks = blocks_q;
				end
			end
			default: begin
				result_d.status = mmgs_pkg::STAT_OK;
			end
		endcase
		case (state_q)
			mmgs_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = mmgs_pkg::S_SCAN;
				end
			end
			mmgs_pkg::S_SCAN: begin
				if (idx_q == LAST) begin
					state_d = mmgs_pkg::S_DRAIN;
				end
			end
			mmgs_pkg::S_DRAIN: begin
				state_d = mmgs_pkg::S_RESP;
			end
			mmgs_pkg::S_RESP: begin
				ram_we  = add_ok;
				state_d = mmgs_pkg::S_IDLE;
			end
			default: begin
				state_d = mmgs_pkg::S_IDLE;
			end
		endcase
	end

	// slot under test this cycle, from the read issued in the previous cycle
	always_comb begin
		hit = 1'b0;
		case (kind_q)
			mmgs_pkg::KIND_ADD: begin
				hit = !valid_q[rd_idx_s1] && !found_q;
			end
			mmgs_pkg::KIND_REMOVE: begin
				hit = valid_q[rd_idx_s1] && (ram_rdata.user == user_q) && !found_q;
			end
			mmgs_pkg::KIND_TICK: begin
				hit = valid_q[rd_idx_s1] && (!found_q || (ram_rdata.rate > best_rate_q));
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			blocks_q  <= mmgs_pkg::BLOCKS_RESET;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				blocks_q <= cfg_wdata;
			end
			rd_vld_s1 <= (state_q == mmgs_pkg::S_SCAN);
			done_q    <= (state_q == mmgs_pkg::S_RESP);
			if (accept) begin
				found_q <= 1'b0;
			end else if (rd_vld_s1 && hit) begin
				found_q <= 1'b1;
			end
			if (state_q == mmgs_pkg::S_RESP) begin
				count_q <= count_d;
				if (add_ok) begin
					valid_q[fidx_q] <= 1'b1;
				end else if (rem_ok) begin
					valid_q[fidx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			kind_q <= cmd.kind;
			user_q <= cmd.user_id;
			rate_q <= (cmd.rate_index > mmgs_pkg::RATE_MAX) ? mmgs_pkg::RATE_MAX :
				cmd.rate_index;
			idx_q  <= '0;
		end else if (state_q == mmgs_pkg::S_SCAN && idx_q != LAST) begin
			idx_q <= idx_q + IW'(1);
		end
		if (rd_vld_s1 && hit) begin
			fidx_q      <= rd_idx_s1;
			best_user_q <= ram_rdata.user;
			best_rate_q <= ram_rdata.rate;
		end
		if (state_q == mmgs_pkg::S_RESP) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`MMGS_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_q) == int'(count_q))
	`MMGS_ASSERT_NOW(a_done_when_idle, done, !busy)
	`MMGS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !done)
	`MMGS_ASSERT_NEXT(a_resp_strobes, state_q == mmgs_pkg::S_RESP, done)

endmodule
